### rtl/accelerometer_from_pose_difference_core_assert.svh
// Assertion macros for the accelerometer core.
// Included by modules that check their own sequencing.
`ifndef ACCELEROMETER_FROM_POSE_DIFFERENCE_CORE_ASSERT_SVH
`define ACCELEROMETER_FROM_POSE_DIFFERENCE_CORE_ASSERT_SVH

// same-cycle implication
`define AFPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("accelerometer core assertion failed");

// next-cycle implication
`define AFPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("accelerometer core assertion failed");

`endif

### rtl/afpd_pkg.sv
// Shared types, constants and helper functions for the accelerometer core.
// No dependencies.
package afpd_pkg;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_USE, ST_FIN} t_state;

    localparam int ATAN_LEN = 24;
    localparam logic signed [25:0] PI_Q20      = 26'sd3294199;
    localparam logic signed [25:0] HALF_PI_Q20 = 26'sd1647099;
    localparam logic signed [25:0] TWO_PI_Q20  = 26'sd6588397;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic [15:0] RATE_RESET = 16'd10;

    // sequencer steps
    localparam logic [3:0] J_VEL_T = 4'd3;
    localparam logic [3:0] J_ACC_0 = 4'd4;
    localparam logic [3:0] J_ACC_T = 4'd7;
    localparam logic [3:0] J_XC    = 4'd8;
    localparam logic [3:0] J_YS    = 4'd9;
    localparam logic [3:0] J_YC    = 4'd10;
    localparam logic [3:0] J_XS    = 4'd11;

    function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
        logic signed [32:0] v;
        case (i)
            5'd0:    v = 33'sd843314857;
            5'd1:    v = 33'sd497837829;
            5'd2:    v = 33'sd263043837;
            5'd3:    v = 33'sd133525159;
            5'd4:    v = 33'sd67021687;
            5'd5:    v = 33'sd33543516;
            5'd6:    v = 33'sd16775851;
            5'd7:    v = 33'sd8388437;
            5'd8:    v = 33'sd4194283;
            5'd9:    v = 33'sd2097149;
            5'd10:   v = 33'sd1048576;
            5'd11:   v = 33'sd524288;
            5'd12:   v = 33'sd262144;
            5'd13:   v = 33'sd131072;
            5'd14:   v = 33'sd65536;
            5'd15:   v = 33'sd32768;
            5'd16:   v = 33'sd16384;
            5'd17:   v = 33'sd8192;
            5'd18:   v = 33'sd4096;
            5'd19:   v = 33'sd2048;
            5'd20:   v = 33'sd1024;
            5'd21:   v = 33'sd512;
            5'd22:   v = 33'sd256;
            5'd23:   v = 33'sd128;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)       r = 32'sh7fffffff;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/afpd_cordic.sv
// Iterative CORDIC giving Q2.30 cosine and sine of a Q4.20 heading.
// Depends on afpd_pkg.
module afpd_cordic #(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [23:0] i_angle,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    localparam int IW = $clog2(STEPS);

    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic               r_neg, r_busy, r_done;
    logic [IW-1:0]      r_i;

    logic signed [25:0] w_a1, w_a2, w_a3;
    logic               w_neg;
    logic signed [33:0] w_dx, w_dy, w_xo, w_yo;

    always_comb begin
        w_a1  = 26'(i_angle);
        w_neg = 1'b0;
        if (w_a1 > afpd_pkg::PI_Q20)       w_a2 = w_a1 - afpd_pkg::TWO_PI_Q20;
        else if (w_a1 < -afpd_pkg::PI_Q20) w_a2 = w_a1 + afpd_pkg::TWO_PI_Q20;
        else                               w_a2 = w_a1;
        if (w_a2 > afpd_pkg::HALF_PI_Q20) begin
            w_a3  = w_a2 - afpd_pkg::PI_Q20;
            w_neg = 1'b1;
        end else if (w_a2 < -afpd_pkg::HALF_PI_Q20) begin
            w_a3  = w_a2 + afpd_pkg::PI_Q20;
            w_neg = 1'b1;
        end else begin
            w_a3  = w_a2;
        end
        w_dx = r_y >>> r_i;
        w_dy = r_x >>> r_i;
        w_xo = r_neg ? -r_x : r_x;
        w_yo = r_neg ? -r_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_i    <= '0;
            r_x    <= afpd_pkg::GAIN_Q30;
            r_y    <= '0;
            r_z    <= 33'(w_a3) <<< 10;
            r_neg  <= w_neg;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - afpd_pkg::atan_q30(5'(r_i));
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + afpd_pkg::atan_q30(5'(r_i));
            end
            if (r_i == IW'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
            r_i <= r_i + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_cos  = w_xo[31:0];
    assign o_sin  = w_yo[31:0];
endmodule

### rtl/accelerometer_from_pose_difference_core.sv
// Top level of the accelerometer core: sequencer, shared multiplier, state.
// Depends on afpd_pkg, afpd_cordic and the assertion macro header.
//
// One pose transaction per tick in, one result transaction out. A single
// 33x33 multiplier is reused for all twelve products (four velocities, four
// accelerations, four rotation terms), each taking a multiply state (ST_MUL)
// and a writeback state (ST_USE), then the load of the result register in
// ST_FIN. The CORDIC starts at acceptance. It delays the rotation products
// only when CORDIC_STEPS exceeds 16. A non-subscribed item skips the products
// and goes straight to ST_FIN for its load. The next item is taken as soon as
// the result is in the output register, even if that result has not yet been
// taken. While an earlier result is still waiting, the load of the next result
// waits too.
`include "accelerometer_from_pose_difference_core_assert.svh"

module accelerometer_from_pose_difference_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [16:0]  i_cfg_wr_data,   // tick_rate_hz
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [119:0] i_s_tdata,       // pose_x, pose_y, pose_z, heading
    input  logic         i_s_tuser,       // subscribed
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // local_acc_x, local_acc_y, local_acc_z, local_acc_turn,
    // world_acc_x, world_acc_y, world_acc_z, world_acc_turn
    output logic [255:0] o_m_tdata
);
    localparam logic signed [65:0] RND30 = 66'sd536870912;

    afpd_pkg::t_state r_state, n_state;
    logic [3:0]         r_j;
    logic [16:0]        r_rate;
    logic               r_sub, r_out_valid;
    logic signed [31:0] r_pin [0:3];
    logic signed [31:0] r_lp  [0:3];
    logic signed [31:0] r_lv  [0:3];
    logic signed [31:0] r_v   [0:3];
    logic signed [31:0] r_acc [0:3];
    logic signed [31:0] r_lx, r_ly;
    logic signed [31:0] r_out [0:7];
    logic signed [65:0] r_prod, r_sum;

    logic               w_in_acc, w_load, w_go;
    logic [1:0]         w_idx;
    logic signed [32:0] w_ma, w_mb, w_rate;
    logic signed [65:0] w_prod, w_rt, w_rx, w_ry;
    logic               w_cdone;
    logic signed [31:0] w_cos, w_sin;

    afpd_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_angle (i_s_tdata[119:96]),
        .o_done  (w_cdone),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // shared multiplier operand selection
    always_comb begin
        w_idx  = r_j[1:0];
        w_rate = 33'($signed({1'b0, r_rate}));
        case (r_j)
            afpd_pkg::J_XC: begin w_ma = 33'(r_acc[0]); w_mb = 33'(w_cos); end
            afpd_pkg::J_YS: begin w_ma = 33'(r_acc[1]); w_mb = 33'(w_sin); end
            afpd_pkg::J_YC: begin w_ma = 33'(r_acc[1]); w_mb = 33'(w_cos); end
            afpd_pkg::J_XS: begin w_ma = 33'(r_acc[0]); w_mb = 33'(w_sin); end
            default: begin
                if (r_j < afpd_pkg::J_ACC_0) w_ma = 33'(r_pin[w_idx]) - 33'(r_lp[w_idx]);
                else                         w_ma = 33'(r_v[w_idx]) - 33'(r_lv[w_idx]);
                w_mb = w_rate;
            end
        endcase
        w_prod = w_ma * w_mb;
        w_rt   = (r_prod + 66'sd8) >>> 4;
        w_rx   = (r_sum + r_prod + RND30) >>> 30;
        w_ry   = (r_sum - r_prod + RND30) >>> 30;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            afpd_pkg::ST_IDLE: if (i_s_tvalid) n_state = i_s_tuser ? afpd_pkg::ST_MUL
                                                                 : afpd_pkg::ST_FIN;
            afpd_pkg::ST_MUL:  if (w_go) n_state = afpd_pkg::ST_USE;
            afpd_pkg::ST_USE:  n_state = (r_j == afpd_pkg::J_XS) ? afpd_pkg::ST_FIN
                                                                : afpd_pkg::ST_MUL;
            afpd_pkg::ST_FIN:  if (w_load) n_state = afpd_pkg::ST_IDLE;
            default:           n_state = afpd_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready = (r_state == afpd_pkg::ST_IDLE);
        w_in_acc   = o_s_tready && i_s_tvalid;
        w_go       = (r_state == afpd_pkg::ST_MUL) && ((r_j < afpd_pkg::J_XC) || w_cdone);
        w_load     = (r_state == afpd_pkg::ST_FIN) && (!r_out_valid || i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= afpd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_rate      <= 17'(afpd_pkg::RATE_RESET);
            r_j         <= '0;
            for (int k = 0; k < 4; k++) begin
                r_lp[k] <= '0;
                r_lv[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_rate <= i_cfg_wr_data;
            if (w_in_acc) begin
                r_sub    <= i_s_tuser;
                r_j      <= '0;
                r_pin[0] <= i_s_tdata[31:0];
                r_pin[1] <= i_s_tdata[63:32];
                r_pin[2] <= i_s_tdata[95:64];
                r_pin[3] <= 32'($signed(i_s_tdata[119:96]));
                if (!i_s_tuser) begin
                    for (int k = 0; k < 4; k++) r_lv[k] <= '0;
                end
            end
            if (w_go) r_prod <= w_prod;
            if (r_state == afpd_pkg::ST_USE) begin
                r_j <= r_j + 1'b1;
                case (r_j)
                    afpd_pkg::J_VEL_T: r_v[3] <= afpd_pkg::sat32(w_rt);
                    afpd_pkg::J_XC:    r_sum  <= r_prod;
                    afpd_pkg::J_YS:    r_lx   <= afpd_pkg::sat32(w_rx);
                    afpd_pkg::J_YC:    r_sum  <= r_prod;
                    afpd_pkg::J_XS:    r_ly   <= afpd_pkg::sat32(w_ry);
                    default: begin
                        if (r_j < afpd_pkg::J_ACC_0) r_v[w_idx]   <= afpd_pkg::sat32(r_prod);
                        else                         r_acc[w_idx] <= afpd_pkg::sat32(r_prod);
                    end
                endcase
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (r_sub) begin
                    r_out[0] <= r_lx;
                    r_out[1] <= r_ly;
                    r_out[2] <= r_acc[2];
                    r_out[3] <= r_acc[3];
                    r_out[4] <= r_acc[0];
                    r_out[5] <= r_acc[1];
                    r_out[6] <= r_acc[2];
                    r_out[7] <= r_acc[3];
                    for (int k = 0; k < 4; k++) begin
                        r_lv[k] <= r_v[k];
                        r_lp[k] <= r_pin[k];
                    end
                end else begin
                    for (int k = 0; k < 8; k++) r_out[k] <= '0;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out[7], r_out[6], r_out[5], r_out[4],
                         r_out[3], r_out[2], r_out[1], r_out[0]};

    `AFPD_ASSERT_NXT(a_unsub_fin, i_clk, i_rst_n, w_in_acc && !i_s_tuser, r_state == afpd_pkg::ST_FIN)
    `AFPD_ASSERT_NXT(a_load_valid, i_clk, i_rst_n, w_load, o_m_tvalid)
    `AFPD_ASSERT_IMP(a_rot_cordic, i_clk, i_rst_n, w_go && (r_j >= afpd_pkg::J_XC), w_cdone)
endmodule

### verif/accel_pose_checker.sv
// Checker for the accelerometer core: watches the register port and both streams,
// predicts each result from the pose history and compares it field by field.
// Depends on afpd_pkg for the angle and gain constants and the reset rate.
module accel_pose_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [16:0]  i_cfg_wr_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [119:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [255:0] i_m_tdata,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ATAN_TBL [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    string field_names [8] = '{"local_acc_x", "local_acc_y", "local_acc_z", "local_acc_turn",
                              "world_acc_x", "world_acc_y", "world_acc_z", "world_acc_turn"};

    logic [16:0]  tick_rate;
    longint       prev_x, prev_y, prev_z, prev_hd;
    longint       prev_vx, prev_vy, prev_vz, prev_vt;
    logic [255:0] accel_queue [$];
    int           fails = 0;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic heading_sin_cos(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        longint pi_q20, hpi_q20, tpi_q20;
        bit flip;
        int steps;
        pi_q20  = longint'(afpd_pkg::PI_Q20);
        hpi_q20 = longint'(afpd_pkg::HALF_PI_Q20);
        tpi_q20 = longint'(afpd_pkg::TWO_PI_Q20);
        x = longint'(afpd_pkg::GAIN_Q30);
        y = 0;
        flip = 0;
        steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        if (ang > pi_q20) ang -= tpi_q20;
        else if (ang < -pi_q20) ang += tpi_q20;
        // fold into the right half plane, negate both afterwards
        if (ang > hpi_q20) begin
            ang -= pi_q20;
            flip = 1;
        end else if (ang < -hpi_q20) begin
            ang += pi_q20;
            flip = 1;
        end
        z = ang * 1024;
        for (int i = 0; i < steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endtask

    task automatic predict_acceleration(input logic sub, input logic [119:0] d,
                                        output logic [255:0] res);
        longint r, px, py, pz, ph, vx, vy, vz, vt, ax, ay, az, at, c, s, lx, ly;
        res = '0;
        if (!sub) begin
            prev_vx = 0; prev_vy = 0; prev_vz = 0; prev_vt = 0;
            return;
        end
        r  = longint'(tick_rate);
        px = longint'(signed'(d[31:0]));
        py = longint'(signed'(d[63:32]));
        pz = longint'(signed'(d[95:64]));
        ph = longint'(signed'(d[119:96]));
        vx = clip32((px - prev_x) * r);
        vy = clip32((py - prev_y) * r);
        vz = clip32((pz - prev_z) * r);
        // Q.20 angle rate rounded to nearest Q16.16
        vt = clip32(((ph - prev_hd) * r + 8) >>> 4);
        ax = clip32((vx - prev_vx) * r);
        ay = clip32((vy - prev_vy) * r);
        az = clip32((vz - prev_vz) * r);
        at = clip32((vt - prev_vt) * r);
        heading_sin_cos(ph, c, s);
        lx = clip32((ax * c + ay * s + (64'sd1 << 29)) >>> 30);
        ly = clip32((ay * c - ax * s + (64'sd1 << 29)) >>> 30);
        res = {at[31:0], az[31:0], ay[31:0], ax[31:0], at[31:0], az[31:0], ly[31:0], lx[31:0]};
        prev_vx = vx; prev_vy = vy; prev_vz = vz; prev_vt = vt;
        prev_x = px; prev_y = py; prev_z = pz; prev_hd = ph;
    endtask

    always @(posedge i_clk) begin
        logic [255:0] want;
        logic [31:0] w, g;
        if (!i_rst_n) begin
            tick_rate = 17'(afpd_pkg::RATE_RESET);
            prev_x = 0; prev_y = 0; prev_z = 0; prev_hd = 0;
            prev_vx = 0; prev_vy = 0; prev_vz = 0; prev_vt = 0;
            accel_queue.delete();
        end else begin
            if (i_cfg_wr_en)
                tick_rate = i_cfg_wr_data;
            if (i_m_tvalid && i_m_tready) begin
                if (accel_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result transaction %h", $realtime, i_m_tdata);
                end else begin
                    want = accel_queue.pop_front();
                    for (int f = 0; f < 8; f++) begin
                        w = want[f*32 +: 32];
                        g = i_m_tdata[f*32 +: 32];
                        if (w !== g) begin
                            fails++;
                            if (fails <= 10)
                                $display("%0t: %s expected %0d got %0d", $realtime,
                                         field_names[f], signed'(w), signed'(g));
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_acceleration(i_s_tuser, i_s_tdata, want);
                accel_queue.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= accel_queue.size();
    end

endmodule

### verif/testbench.sv
// Top of the accelerometer core testbench: clock, reset, pose stimulus and verdict.
// Depends on the core RTL, afpd_pkg and accel_pose_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_wr_en = 0;
    logic [16:0]  i_cfg_wr_data = '0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [119:0] i_s_tdata = '0;    // pose_x, pose_y, pose_z, heading
    logic         i_s_tuser = 0;     // subscribed
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [255:0] o_m_tdata;         // local x,y,z,turn then world x,y,z,turn
    int           fail_count, pending;

    int           burst_left = 0;
    bit           gaps_on = 1;
    int           ready_mode = 0;
    int           cyc = 0;
    logic [31:0]  cur_x = 0, cur_y = 0, cur_z = 0;
    logic [23:0]  cur_h = 0;

    always #1 i_clk = ~i_clk;

    accelerometer_from_pose_difference_core DUT (.*);

    accel_pose_checker checker_u (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_wr_data,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern, switching at random among four ready modes
    always @(posedge i_clk) begin
        cyc++;
        if (cyc % 400 == 0)
            ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            2: i_m_tready <= ($urandom_range(0, 7) == 0);
            default: i_m_tready <= cyc[3] | cyc[1];
        endcase
    end

    task automatic send_pose(input logic sub, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [23:0] h);
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= sub;
        i_s_tdata  <= {h, z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
    endtask

    // drain, let the core settle, then write the rate register
    task automatic set_tick_rate(input logic [16:0] rate);
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (30) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= rate;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_motion(input int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                // smooth trajectory with random steps
                cur_x += 32'($urandom_range(0, 8191)) - 32'd4096;
                cur_y += 32'($urandom_range(0, 8191)) - 32'd4096;
                cur_z += 32'($urandom_range(0, 511)) - 32'd256;
                cur_h += 24'($urandom_range(0, 32767)) - 24'd16384;
                send_pose(1'b1, cur_x, cur_y, cur_z, cur_h);
            end else if (pick < 9) begin
                cur_x = $urandom; cur_y = $urandom; cur_z = $urandom;
                cur_h = 24'($urandom);
                send_pose(1'b1, cur_x, cur_y, cur_z, cur_h);
            end else begin
                send_pose(1'b0, $urandom, $urandom, $urandom, 24'($urandom));
            end
        end
    endtask

    initial begin
        logic [16:0] rate_pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset rate, extremes of pose and heading, unsubscribed
        send_pose(1'b1, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 24'd1000);
        send_pose(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 24'h7fffff);
        send_pose(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 24'h800000);
        send_pose(1'b0, 32'h1234_5678, 32'h0, 32'hffff_ffff, 24'h123456);
        send_pose(1'b1, 32'h0, 32'h0, 32'h0, 24'd3294199);
        send_pose(1'b1, 32'h100, 32'h200, 32'h300, 24'd3294200);
        send_pose(1'b1, 32'h100, 32'h200, 32'h300, -24'sd3294200);
        send_pose(1'b1, 32'h200, 32'h400, 32'h600, 24'd1647099);
        send_pose(1'b1, 32'h300, 32'h600, 32'h900, 24'd1647100);
        send_pose(1'b1, 32'h400, 32'h800, 32'hc00, -24'sd1647100);
        set_tick_rate(17'd0);
        send_pose(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 24'h7fffff);
        send_pose(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h2, 24'h800000);
        set_tick_rate(17'd1);
        send_pose(1'b1, 32'h0010_0000, 32'h0020_0000, 32'h0, 24'd500000);
        send_pose(1'b1, 32'h0011_0000, 32'h0020_8000, 32'h0, 24'd600000);
        set_tick_rate(17'd100000);
        send_pose(1'b1, 32'h0011_0001, 32'h0020_8000, 32'h0, 24'd600001);
        send_pose(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 24'h800000);
        send_pose(1'b0, 32'h0, 32'h0, 32'h0, 24'h0);
        set_tick_rate(17'h1ffff);
        send_pose(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 24'h7fffff);
        send_pose(1'b1, 32'h7fff_fff0, 32'h8000_0010, 32'h8000_0000, 24'h7ffff0);

        // random phases at assorted rates, with and without sender gaps
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 6))
                0: rate_pick = 17'd0;
                1: rate_pick = 17'd1;
                2: rate_pick = 17'd100000;
                3: rate_pick = 17'h1ffff;
                4: rate_pick = 17'd60;
                default: rate_pick = 17'($urandom_range(1, 100000));
            endcase
            set_tick_rate(rate_pick);
            gaps_on = (ph % 3 != 2);
            send_motion(193);
        end

        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
